// File: sv/ubxr_pkg.sv
// Shared types and constants for the UBX frame receiver.
// No dependencies; imported by ubxr_parser and ubx_frame_receiver.
`default_nettype none

package ubxr_pkg;

  // Frame bytes
  localparam logic [7:0] SYNC1     = 8'hB5;
  localparam logic [7:0] SYNC2     = 8'h62;
  localparam logic [7:0] ACK_CLASS = 8'h05;
  localparam logic [7:0] ACK_ID    = 8'h01;

  // Result event codes
  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_DATA = 3'd1;
  localparam logic [2:0] EV_GOOD = 3'd2;
  localparam logic [2:0] EV_BAD  = 3'd3;
  localparam logic [2:0] EV_ACK  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_EXPECT_ACK     = 2'd0;
  localparam logic [1:0] REG_EXPECTED_CLASS = 2'd1;
  localparam logic [1:0] REG_EXPECTED_ID    = 2'd2;

  typedef enum logic [13:0] {
    PH_IDLE  = 14'b00000000000001,
    PH_ACK0  = 14'b00000000000010,
    PH_ACK1  = 14'b00000000000100,
    PH_ACK2  = 14'b00000000001000,
    PH_ACK3  = 14'b00000000010000,
    PH_HDR0  = 14'b00000000100000,
    PH_HDR1  = 14'b00000001000000,
    PH_CLASS = 14'b00000010000000,
    PH_ID    = 14'b00000100000000,
    PH_LEN0  = 14'b00001000000000,
    PH_LEN1  = 14'b00010000000000,
    PH_DATA  = 14'b00100000000000,
    PH_CKA   = 14'b01000000000000,
    PH_CKB   = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] idx;
    logic [7:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] frame_length;
  } res_t;

endpackage

`default_nettype wire

// File: sv/ubxr_parser.sv
// Parser state, configuration registers and the per-word next-state logic.
// Depends on ubxr_pkg.
`default_nettype none

module ubxr_parser import ubxr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_wr_t    cfg_wr,
  output res_t            res
);

  logic        expect_ack_r, expect_ack_nxt;
  logic [7:0]  exp_class_r, exp_class_nxt;
  logic [7:0]  exp_id_r, exp_id_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] decl_len_r, decl_len_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  rx_sum_a_r, rx_sum_a_nxt;

  logic [7:0]  sa_acc;
  logic [7:0]  sb_acc;
  logic [15:0] left_dec;
  logic [15:0] len_full;
  phase_t      search;

  assign sa_acc   = sum_a_r + rx_byte;
  assign sb_acc   = sum_b_r + sa_acc;
  assign left_dec = (left_r != 16'd0) ? left_r - 16'd1 : left_r;
  assign len_full = {rx_byte, decl_len_r[7:0]};
  assign search   = expect_ack_r ? PH_ACK0 : PH_HDR0;

  always_comb begin
    expect_ack_nxt = expect_ack_r;
    exp_class_nxt  = exp_class_r;
    exp_id_nxt     = exp_id_r;
    phase_nxt      = phase_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    decl_len_nxt   = decl_len_r;
    left_nxt       = left_r;
    rx_sum_a_nxt   = rx_sum_a_r;
    res            = '0;
    res.event_res  = EV_NONE;

    if (step) begin
      unique case (phase_r)
        PH_ACK0, PH_HDR0: begin
          if (rx_byte == SYNC1) begin
            phase_nxt = (phase_r == PH_ACK0) ? PH_ACK1 : PH_HDR1;
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end
        end
        PH_ACK1: phase_nxt = (rx_byte == SYNC2) ? PH_ACK2 : search;
        PH_HDR1: phase_nxt = (rx_byte == SYNC2) ? PH_CLASS : search;
        PH_ACK2: phase_nxt = (rx_byte == ACK_CLASS) ? PH_ACK3 : search;
        PH_ACK3: begin
          if (rx_byte == ACK_ID) begin
            res.event_res = EV_ACK;
            phase_nxt     = PH_IDLE;
          end else begin
            phase_nxt = search;
          end
        end
        PH_CLASS: begin
          sum_a_nxt = sa_acc;
          sum_b_nxt = sb_acc;
          phase_nxt = (rx_byte == exp_class_r) ? PH_ID : search;
        end
        PH_ID: begin
          sum_a_nxt = sa_acc;
          sum_b_nxt = sb_acc;
          phase_nxt = (rx_byte == exp_id_r) ? PH_LEN0 : search;
        end
        PH_LEN0: begin
          sum_a_nxt    = sa_acc;
          sum_b_nxt    = sb_acc;
          decl_len_nxt = {8'd0, rx_byte};
          phase_nxt    = PH_LEN1;
        end
        PH_LEN1: begin
          sum_a_nxt    = sa_acc;
          sum_b_nxt    = sb_acc;
          decl_len_nxt = len_full;
          left_nxt     = len_full;
          // empty payload skips straight to the checksum
          phase_nxt    = (len_full == 16'd0) ? PH_CKA : PH_DATA;
        end
        PH_DATA: begin
          sum_a_nxt         = sa_acc;
          sum_b_nxt         = sb_acc;
          res.event_res     = EV_DATA;
          res.payload_byte  = rx_byte;
          res.payload_index = decl_len_r - left_r;
          res.frame_length  = decl_len_r;
          left_nxt          = left_dec;
          if (left_dec == 16'd0) begin
            phase_nxt = PH_CKA;
          end
        end
        PH_CKA: begin
          rx_sum_a_nxt = rx_byte;
          phase_nxt    = PH_CKB;
        end
        PH_CKB: begin
          res.event_res    = (rx_sum_a_r == sum_a_r && rx_byte == sum_b_r) ? EV_GOOD : EV_BAD;
          res.frame_length = decl_len_r;
          phase_nxt        = search;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (cfg_wr.vld) begin
      unique case (cfg_wr.idx)
        REG_EXPECT_ACK: begin
          expect_ack_nxt = cfg_wr.data[0];
          phase_nxt      = cfg_wr.data[0] ? PH_ACK0 : PH_HDR0;
        end
        REG_EXPECTED_CLASS: exp_class_nxt = cfg_wr.data;
        REG_EXPECTED_ID:    exp_id_nxt    = cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_ack_r <= 1'b1;
      exp_class_r  <= '0;
      exp_id_r     <= '0;
      phase_r      <= PH_ACK0;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      decl_len_r   <= '0;
      left_r       <= '0;
      rx_sum_a_r   <= '0;
    end else begin
      expect_ack_r <= expect_ack_nxt;
      exp_class_r  <= exp_class_nxt;
      exp_id_r     <= exp_id_nxt;
      phase_r      <= phase_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      decl_len_r   <= decl_len_nxt;
      left_r       <= left_nxt;
      rx_sum_a_r   <= rx_sum_a_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/ubx_frame_receiver.sv
// Top level of the UBX frame receiver: input word register, parser, result register.
// Depends on ubxr_pkg and ubxr_parser.
//
//   channel  direction  handshake              payload
//   in_      sink       in_valid / in_ready    in_rx_byte
//   out_     source     out_valid / out_ready  out_event_res, out_payload_byte,
//                                              out_payload_index, out_frame_length
//   cfg_     sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every input word gives exactly one result word: it is held in the input register,
// then the parser logic loads the result register once that is free or being taken,
// which raises out_valid. Sustained rate is one word per cycle while out_ready is high;
// the parser step is the only loop.
// A stall on out_ready holds the result register and then the input register;
// in_ready drops only when both are full and out_ready is low. cfg_ready is always high.
// Reset (rst_n low, synchronous) arms acknowledge mode and empties both registers.
`default_nettype none

module ubx_frame_receiver import ubxr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_payload_index,
  output logic [15:0]      out_frame_length,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  res_t       out_r;
  res_t       res;
  logic       advance;
  cfg_wr_t    cfg_wr;

  // advance the held word into the parser whenever the result register is free or being taken
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  assign cfg_ready   = 1'b1;
  assign cfg_wr.vld  = cfg_valid;
  assign cfg_wr.idx  = cfg_index;
  assign cfg_wr.data = cfg_data;

  ubxr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg_wr  (cfg_wr),
    .res     (res)
  );

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_res     = out_r.event_res;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_index = out_r.payload_index;
  assign out_frame_length  = out_r.frame_length;

endmodule

`default_nettype wire
